@@ rtl/bia_pkg.sv @@
// shared types and constants of the bitmap id allocator
package bia_pkg;

  localparam int unsigned NumWordsDefault = 64;
  localparam int unsigned WordBits = 32;
  localparam int unsigned IdWidth = 12;
  localparam int unsigned CountWidth = 6;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_MARK = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [4:0]            bit_sel;
    logic                  idx_ok;
    logic [CountWidth-1:0] count;
    logic                  one_based;
  } bia_req_t;

endpackage

@@ rtl/bia_front.sv @@
// front end: id decode, config register and two-entry request queue
module bia_front import bia_pkg::*; #(
  parameter int unsigned NUM_WORDS = NumWordsDefault,
  parameter int unsigned WW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            cmd_i,
  input  logic [IdWidth-1:0]    id_i,
  input  logic [CountWidth-1:0] count_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_data_i,
  output logic                  q_valid_o,
  input  logic                  q_pop_i,
  output bia_req_t              q_req_o,
  output logic [WW-1:0]         q_word_o
);

  localparam logic [15:0] NumIds = 16'(NUM_WORDS * WordBits);

  logic from_zero_q;
  bia_req_t req_q [2];
  logic [WW-1:0] word_q [2];
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  logic [15:0] n;
  bia_req_t req_new;
  logic push, pop;

  always_comb begin
    n = {4'b0, id_i} - {15'b0, ~from_zero_q};
    req_new.cmd = cmd_i;
    req_new.bit_sel = n[4:0];
    req_new.idx_ok = !(!from_zero_q && id_i == '0) && (n < NumIds);
    req_new.count = count_i;
    req_new.one_based = ~from_zero_q;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign pop = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o = req_q[rd_ptr_q];
  assign q_word_o = word_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      from_zero_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (cfg_valid_i) begin
        from_zero_q <= cfg_data_i;
      end
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      req_q[wr_ptr_q] <= req_new;
      word_q[wr_ptr_q] <= n[WW+4:5];
    end
  end

endmodule

@@ rtl/bia_back.sv @@
// back end: bitmap memory, window scan and result register
module bia_back import bia_pkg::*; #(
  parameter int unsigned NUM_WORDS = NumWordsDefault,
  parameter int unsigned WW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  bia_req_t           q_req_i,
  input  logic [WW-1:0]      q_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [IdWidth-1:0] first_id_o,
  output logic               ok_o,
  output logic               is_used_o
);

  localparam logic [2:0] S_CLR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD = 3'd2;
  localparam logic [2:0] S_EXE = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [WW-1:0] LastWord = WW'(NUM_WORDS - 1);

  logic [WordBits-1:0] mem [NUM_WORDS];
  logic [WordBits-1:0] data_q;
  logic [2:0] state_q, state_d;
  logic [WW-1:0] word_q, word_d;
  logic [5:0] top_q, top_d;
  bia_req_t req_q;
  logic out_valid_q, out_valid_d;
  logic [IdWidth-1:0] first_q, first_d;
  logic ok_q, ok_d, used_q, used_d;

  logic we;
  logic [WW-1:0] waddr;
  logic [WordBits-1:0] wdata;
  logic slot_free;
  logic [WordBits-1:0] run_mask, hit, bit_mask;
  logic [5:0] low;
  logic [15:0] first_full;

  always_comb begin
    run_mask = WordBits'((33'd1 << req_q.count) - 33'd1) << (top_q - req_q.count);
    hit = data_q & run_mask;
    low = 6'd0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (hit[i]) begin
        low = 6'(i);
      end
    end
    bit_mask = 32'h8000_0000 >> req_q.bit_sel;
    first_full = ({6'b0, 10'(word_q)} << 5) + {10'b0, 6'd32 - top_q}
      + {15'b0, req_q.one_based};
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign q_pop_o = (state_q == S_IDLE) && slot_free && q_valid_i;

  always_comb begin
    state_d = state_q;
    word_d = word_q;
    top_d = top_q;
    out_valid_d = out_valid_q && !out_ready_i;
    first_d = first_q;
    ok_d = ok_q;
    used_d = used_q;
    we = 1'b0;
    waddr = word_q;
    wdata = '0;
    case (state_q)
      S_CLR: begin
        we = 1'b1;
        word_d = word_q + WW'(1);
        if (word_q == LastWord) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_pop_o) begin
          if (q_req_i.cmd == CMD_ALLOC) begin
            word_d = '0;
            if (q_req_i.count >= 6'd1 && q_req_i.count <= 6'd32) begin
              state_d = S_RD;
            end else begin
              out_valid_d = 1'b1;
              first_d = '0;
              ok_d = 1'b0;
              used_d = 1'b0;
            end
          end else begin
            word_d = q_word_i;
            if (q_req_i.idx_ok) begin
              state_d = S_RD;
            end else begin
              out_valid_d = 1'b1;
              first_d = '0;
              ok_d = 1'b0;
              used_d = 1'b0;
            end
          end
        end
      end
      S_RD: begin
        state_d = S_EXE;
        top_d = 6'd32;
      end
      S_EXE: begin
        if (req_q.cmd == CMD_ALLOC) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_IDLE;
          out_valid_d = 1'b1;
          first_d = '0;
          ok_d = 1'b1;
          used_d = 1'b0;
          case (req_q.cmd)
            CMD_RELEASE: begin
              we = 1'b1;
              wdata = data_q & ~bit_mask;
            end
            CMD_MARK: begin
              we = 1'b1;
              wdata = data_q | bit_mask;
            end
            default: begin
              used_d = |(data_q & bit_mask);
            end
          endcase
        end
      end
      S_SCAN: begin
        if (top_q >= req_q.count) begin
          if (hit == '0) begin
            we = 1'b1;
            wdata = data_q | run_mask;
            state_d = S_IDLE;
            out_valid_d = 1'b1;
            first_d = first_full[IdWidth-1:0];
            ok_d = 1'b1;
            used_d = 1'b0;
          end else begin
            top_d = low;
          end
        end else if (word_q == LastWord) begin
          state_d = S_IDLE;
          out_valid_d = 1'b1;
          first_d = '0;
          ok_d = 1'b0;
          used_d = 1'b0;
        end else begin
          word_d = word_q + WW'(1);
          state_d = S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      word_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      word_q <= word_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    first_q <= first_d;
    ok_q <= ok_d;
    used_q <= used_d;
    if (q_pop_o) begin
      req_q <= q_req_i;
    end
    data_q <= mem[word_q];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign first_id_o = first_q;
  assign ok_o = ok_q;
  assign is_used_o = used_q;

`ifndef SYNTHESIS
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !q_pop_o) else $error("pop during clear");
  a_fail_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ok_q) |-> (first_q == '0 && !used_q))
    else $error("failed result carries data");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !we) else $error("write while idle");
`endif

endmodule

@@ rtl/bitmap_id_allocator.sv @@
// top level of the bitmap id allocator
// channel   direction  handshake                      content
// s_axis    in         s_axis_tvalid/s_axis_tready    command, id, count
// m_axis    out        m_axis_tvalid/m_axis_tready    first_id, ok, is_used
// cfg       in         cfg_valid_i/cfg_ready_o        id base select
// release, mark, query: for a valid id one memory read and, except query, one write
// allocate: reads each word (S_RD, S_EXE), then steps the window down in S_SCAN and moves on,
// up to NUM_WORDS words
// after reset a clearing pass zeroes all NUM_WORDS words before the first request is served
// a two-entry queue takes input, while not full, as the back end scans or a result waits
module bitmap_id_allocator import bia_pkg::*; #(
  parameter int unsigned NUM_WORDS = NumWordsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // command, id, count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // first_id, ok, is_used
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  localparam int unsigned WW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  logic q_valid, q_pop;
  bia_req_t q_req;
  logic [WW-1:0] q_word;
  logic [IdWidth-1:0] first_id;
  logic ok, is_used;

  assign cfg_ready_o = 1'b1;

  bia_front #(.NUM_WORDS(NUM_WORDS), .WW(WW)) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .cmd_i(s_axis_tdata[1:0]),
    .id_i(s_axis_tdata[13:2]),
    .count_i(s_axis_tdata[19:14]),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i(cfg_data_i),
    .q_valid_o(q_valid),
    .q_pop_i(q_pop),
    .q_req_o(q_req),
    .q_word_o(q_word)
  );

  bia_back #(.NUM_WORDS(NUM_WORDS), .WW(WW)) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .q_valid_i(q_valid),
    .q_pop_o(q_pop),
    .q_req_i(q_req),
    .q_word_i(q_word),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .first_id_o(first_id),
    .ok_o(ok),
    .is_used_o(is_used)
  );

  assign m_axis_tdata = {2'b0, is_used, ok, first_id};

endmodule
